FILE: rtl/wlpf_pkg.sv
// Package for the WAV loop point finder: beat types of the byte and result channels.
// No dependencies.
`default_nettype none

package wlpf_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic        found;
		logic [31:0] lp_start;
		logic [31:0] lp_end;
	} out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/wav_loop_point_finder_core.sv
// Top level of the WAV loop point finder: input beat register, parser, result register.
// Depends on wlpf_pkg and wlpf_parser.
`default_nettype none

// Streams a RIFF/WAVE file one byte per beat and reports the first loop of the
// first smpl chunk. Every byte beat is caught in an input register and parsed
// from there; one result beat leaves on the beat flagged final_byte, after which
// the parser is back in its reset state for the next file. Throughput is one byte
// per cycle; the input side holds only while a final beat waits for the result
// register, which frees as soon as the previous result is taken.
// The final byte passes from the input register through the parser into the result register.
// found is 0 (with zero loop points) on a bad RIFF or WAVE tag, a zero loop count,
// no smpl chunk, or a file that ends early.
module wav_loop_point_finder_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_ready,
	input  wlpf_pkg::in_beat_t   byte_data,
	output logic                 loop_valid,
	input  wire                  loop_ready,
	output wlpf_pkg::out_beat_t  loop_data
);
	import wlpf_pkg::*;

	logic      valid_s1;
	in_beat_t  data_s1;
	logic      out_free;
	logic      advance;
	out_beat_t result;
	logic      out_valid_q;
	out_beat_t out_data_q;

	assign out_free   = !out_valid_q || loop_ready;
	assign advance    = valid_s1 && (!data_s1.final_byte || out_free);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= byte_data;
		end
	end

	wlpf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (data_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && data_s1.final_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && data_s1.final_byte) begin
			out_data_q <= result;
		end
	end

	assign loop_valid = out_valid_q;
	assign loop_data  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/wlpf_parser.sv
// RIFF/WAVE chunk walker: parse state registers and the per-byte next-state logic.
// Depends on wlpf_pkg.
`default_nettype none

module wlpf_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wlpf_pkg::in_beat_t   beat,
	output wlpf_pkg::out_beat_t  result
);
	import wlpf_pkg::*;

	typedef enum logic [7:0] {
		PH_RIFF  = 8'b0000_0001,
		PH_RSIZE = 8'b0000_0010,
		PH_WAVE  = 8'b0000_0100,
		PH_CTAG  = 8'b0000_1000,
		PH_CSIZE = 8'b0001_0000,
		PH_SKIP  = 8'b0010_0000,
		PH_SMPL  = 8'b0100_0000,
		PH_DONE  = 8'b1000_0000
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_SMPL = 32'h6c70_6d73;

	localparam logic [5:0] OFS_COUNT = 6'd28;
	localparam logic [5:0] OFS_START = 6'd44;
	localparam logic [5:0] OFS_END   = 6'd48;

	phase_t      phase_q, phase_n;
	logic [1:0]  bw_q, bw_n;
	logic [31:0] word_q, word_n;
	logic [31:0] skip_q, skip_n;
	logic [5:0]  ofs_q, ofs_n;
	logic [31:0] start_q, start_n;
	logic [31:0] end_q, end_n;
	logic        hit_q, hit_n;

	logic [31:0] word_sh;
	logic        word_full;
	logic [31:0] skip_dec;

	assign word_sh   = {beat.data_byte, word_q[31:8]};
	assign word_full = (bw_q == 2'd3);
	assign skip_dec  = skip_q - 32'd1;

	always_comb begin
		phase_n = phase_q;
		bw_n    = bw_q;
		word_n  = word_q;
		skip_n  = skip_q;
		ofs_n   = ofs_q;
		start_n = start_q;
		end_n   = end_q;
		hit_n   = hit_q;
		case (phase_q)
			PH_RIFF: begin
				word_n = word_sh;
				bw_n   = bw_q + 2'd1;
				if (word_full)
					phase_n = (word_sh == TAG_RIFF) ? PH_RSIZE : PH_DONE;
			end
			PH_RSIZE: begin
				word_n = word_sh;
				bw_n   = bw_q + 2'd1;
				if (word_full)
					phase_n = PH_WAVE;
			end
			PH_WAVE: begin
				word_n = word_sh;
				bw_n   = bw_q + 2'd1;
				if (word_full)
					phase_n = (word_sh == TAG_WAVE) ? PH_CTAG : PH_DONE;
			end
			PH_CTAG: begin
				word_n = word_sh;
				bw_n   = bw_q + 2'd1;
				if (word_full) begin
					hit_n   = 1'b0;
					// bit 0 of the offset flags a smpl chunk until the size is in
					ofs_n   = (word_sh == TAG_SMPL) ? 6'd1 : 6'd0;
					phase_n = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				word_n = word_sh;
				bw_n   = bw_q + 2'd1;
				if (word_full) begin
					if (ofs_q == 6'd1) begin
						ofs_n   = 6'd0;
						word_n  = 32'd0;
						phase_n = PH_SMPL;
					end else begin
						skip_n  = word_sh;
						phase_n = (word_sh == 32'd0) ? PH_CTAG : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0)
					phase_n = PH_CTAG;
			end
			PH_SMPL: begin
				ofs_n = ofs_q + 6'd1;
				if (ofs_q inside {[OFS_COUNT:OFS_COUNT + 6'd3]}) begin
					word_n = word_sh;
					if (ofs_q == OFS_COUNT + 6'd3 && word_sh == 32'd0) begin
						ofs_n   = ofs_q;
						phase_n = PH_DONE;
					end
				end else if (ofs_q inside {[OFS_START:OFS_START + 6'd3]}) begin
					start_n = {beat.data_byte, start_q[31:8]};
				end else if (ofs_q inside {[OFS_END:OFS_END + 6'd3]}) begin
					end_n = {beat.data_byte, end_q[31:8]};
					if (ofs_q == OFS_END + 6'd3) begin
						ofs_n   = ofs_q;
						hit_n   = 1'b1;
						phase_n = PH_DONE;
					end
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase
	end

	always_comb begin
		result.found    = hit_n;
		result.lp_start = hit_n ? start_n : 32'd0;
		result.lp_end   = hit_n ? end_n : 32'd0;
	end

	// the final beat is parsed, reported, and then everything returns to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			bw_q    <= 2'd0;
			word_q  <= 32'd0;
			skip_q  <= 32'd0;
			ofs_q   <= 6'd0;
			start_q <= 32'd0;
			end_q   <= 32'd0;
			hit_q   <= 1'b0;
		end else if (step) begin
			if (beat.final_byte) begin
				phase_q <= PH_RIFF;
				bw_q    <= 2'd0;
				word_q  <= 32'd0;
				skip_q  <= 32'd0;
				ofs_q   <= 6'd0;
				start_q <= 32'd0;
				end_q   <= 32'd0;
				hit_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				bw_q    <= bw_n;
				word_q  <= word_n;
				skip_q  <= skip_n;
				ofs_q   <= ofs_n;
				start_q <= start_n;
				end_q   <= end_n;
				hit_q   <= hit_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb_wav_loop_point_finder_core.sv
// Testbench for wav_loop_point_finder_core: whole RIFF/WAVE files streamed as byte beats,
// results compared with a behavioral loop point parser kept in this module, or with the
// expected beat of a pinned row. Depends on wlpf_pkg and the core RTL.
`default_nettype none

module tb_wav_loop_point_finder_core;
	import wlpf_pkg::*;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_SMPL = 32'h6c70_6d73;
	localparam int OFS_COUNT = 28;
	localparam int OFS_START = 44;
	localparam int OFS_END = 48;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int TOTAL_BYTES = 1600;
	localparam out_beat_t NO_LOOP = '0;

	typedef enum logic [2:0] {
		P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_CHUNK_TAG,
		P_CHUNK_SIZE, P_SKIP_BODY, P_SMPL_BODY, P_IGNORE
	} parse_phase_t;

	typedef enum logic [2:0] {
		FK_WAV, FK_BAD_RIFF, FK_BAD_WAVE, FK_NOISE, FK_HUGE_CHUNK
	} file_kind_t;

	// one file to stream; keep != 0 cuts the file to that many bytes
	typedef struct packed {
		file_kind_t  kind;
		logic [7:0]  pre;
		logic        zero_size;
		logic [31:0] count;
		logic [31:0] first_smp;
		logic [31:0] last_smp;
		logic [31:0] smpl_size;
		logic [15:0] keep;
		logic        pinned;
		out_beat_t   want;
	} file_row_t;

	file_row_t dir_rows [15] = '{
		'{FK_NOISE, 8'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'd52, 16'd1, 1'b1, NO_LOOP},
		'{FK_BAD_RIFF, 8'd1, 1'b0, 32'h1, 32'h5, 32'h6, 32'd52, 16'd0, 1'b1, NO_LOOP},
		'{FK_BAD_WAVE, 8'd1, 1'b0, 32'h1, 32'h5, 32'h6, 32'd52, 16'd0, 1'b1, NO_LOOP},
		'{FK_WAV, 8'd0, 1'b0, 32'h1, 32'h0, 32'hffff_ffff, 32'd52, 16'd0, 1'b1,
			'{1'b1, 32'h0, 32'hffff_ffff}},
		'{FK_WAV, 8'd2, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'd60, 16'd0, 1'b1,
			'{1'b1, 32'hffff_ffff, 32'h0}},
		// zero loop count
		'{FK_WAV, 8'd1, 1'b0, 32'h0, 32'h5, 32'h6, 32'd52, 16'd0, 1'b1, NO_LOOP},
		// declared smpl size too small, reads still go to offset 51
		'{FK_WAV, 8'd3, 1'b0, 32'h0100_0000, 32'h1234_5678, 32'h9abc_def0, 32'd4, 16'd0,
			1'b1, '{1'b1, 32'h1234_5678, 32'h9abc_def0}},
		// ends one byte short of the loop end, then exactly on it
		'{FK_WAV, 8'd0, 1'b0, 32'h1, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'd52, 16'd71, 1'b1,
			NO_LOOP},
		'{FK_WAV, 8'd0, 1'b0, 32'h1, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'd52, 16'd72, 1'b1,
			'{1'b1, 32'ha5a5_a5a5, 32'h5a5a_5a5a}},
		'{FK_WAV, 8'd0, 1'b0, 32'h1, 32'h5, 32'h6, 32'd52, 16'd6, 1'b1, NO_LOOP},
		'{FK_WAV, 8'd0, 1'b0, 32'h1, 32'h5, 32'h6, 32'd52, 16'd10, 1'b1, NO_LOOP},
		'{FK_WAV, 8'd1, 1'b0, 32'h1, 32'h5, 32'h6, 32'd52, 16'd14, 1'b1, NO_LOOP},
		'{FK_HUGE_CHUNK, 8'd1, 1'b1, 32'h1, 32'h5, 32'h6, 32'd52, 16'd0, 1'b1, NO_LOOP},
		'{FK_WAV, 8'd2, 1'b1, 32'h7, 32'h100, 32'h8000_0000, 32'd0, 16'd0, 1'b0, NO_LOOP},
		'{FK_NOISE, 8'd0, 1'b0, 32'h0, 32'h0, 32'h0, 32'd0, 16'd9, 1'b0, NO_LOOP}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_ready;
	in_beat_t  byte_data = '0;
	logic      loop_valid;
	logic      loop_ready = 1'b0;
	out_beat_t loop_data;

	logic        no_idle = 1'b0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	logic [7:0]  file_q [$];
	file_row_t   pin_q [$];
	out_beat_t   loop_q [$];

	// parser model state
	parse_phase_t parse_ph;
	logic [1:0]   word_pos;
	logic [31:0]  word_sr;
	logic [31:0]  skip_left;
	logic [5:0]   body_ofs;
	logic         is_smpl;
	logic [31:0]  start_v;
	logic [31:0]  end_v;
	logic         hit;

	wav_loop_point_finder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.loop_valid (loop_valid),
		.loop_ready (loop_ready),
		.loop_data  (loop_data)
	);

	always #4 clk = ~clk;

	function automatic void clear_parser();
		parse_ph = P_RIFF_TAG;
		word_pos = '0;
		word_sr = '0;
		skip_left = '0;
		body_ofs = '0;
		is_smpl = 1'b0;
		start_v = '0;
		end_v = '0;
		hit = 1'b0;
	endfunction

	// little-endian word assembly; true on the fourth byte
	function automatic logic shift_word(logic [7:0] b);
		logic full;
		word_sr = {b, word_sr[31:8]};
		full = (word_pos == 2'd3);
		word_pos = word_pos + 2'd1;
		return full;
	endfunction

	function automatic void parse_wav_byte(logic [7:0] b);
		case (parse_ph)
			P_RIFF_TAG: if (shift_word(b))
				parse_ph = (word_sr == TAG_RIFF) ? P_RIFF_SIZE : P_IGNORE;
			P_RIFF_SIZE: if (shift_word(b))
				parse_ph = P_WAVE_TAG;
			P_WAVE_TAG: if (shift_word(b))
				parse_ph = (word_sr == TAG_WAVE) ? P_CHUNK_TAG : P_IGNORE;
			P_CHUNK_TAG: if (shift_word(b)) begin
				hit = 1'b0;
				is_smpl = (word_sr == TAG_SMPL);
				parse_ph = P_CHUNK_SIZE;
			end
			P_CHUNK_SIZE: if (shift_word(b)) begin
				if (is_smpl) begin
					body_ofs = '0;
					word_sr = '0;
					parse_ph = P_SMPL_BODY;
				end else begin
					skip_left = word_sr;
					parse_ph = (word_sr == 0) ? P_CHUNK_TAG : P_SKIP_BODY;
				end
			end
			P_SKIP_BODY: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 0)
					parse_ph = P_CHUNK_TAG;
			end
			P_SMPL_BODY: begin
				// size of the smpl chunk is not used: offsets 28..31 are always read, 32..51 unless the loop count is zero
				if (body_ofs >= OFS_COUNT && body_ofs < OFS_COUNT + 4) begin
					word_sr = {b, word_sr[31:8]};
					if (body_ofs == OFS_COUNT + 3 && word_sr == 0)
						parse_ph = P_IGNORE;
				end else if (body_ofs >= OFS_START && body_ofs < OFS_START + 4) begin
					start_v = {b, start_v[31:8]};
				end else if (body_ofs >= OFS_END && body_ofs < OFS_END + 4) begin
					end_v = {b, end_v[31:8]};
					if (body_ofs == OFS_END + 3) begin
						hit = 1'b1;
						parse_ph = P_IGNORE;
					end
				end
				if (parse_ph == P_SMPL_BODY)
					body_ofs = body_ofs + 6'd1;
			end
			default: ;
		endcase
	endfunction

	function automatic void put_word(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_q.push_back(w[8*i +: 8]);
	endfunction

	function automatic void put_noise(int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom));
	endfunction

	// any chunk tag but smpl; often a near miss of it
	function automatic logic [31:0] other_tag();
		logic [31:0] t;
		t = $urandom;
		if ($urandom_range(3) == 0)
			t = TAG_SMPL ^ (32'd1 << $urandom_range(31));
		if (t == TAG_SMPL)
			t = ~t;
		return t;
	endfunction

	function automatic void build_file(file_row_t r);
		logic [31:0] hdr_riff;
		logic [31:0] hdr_wave;
		int          n;
		file_q.delete();
		hdr_riff = TAG_RIFF;
		hdr_wave = TAG_WAVE;
		if (r.kind == FK_BAD_RIFF)
			hdr_riff ^= 32'd1 << $urandom_range(31);
		if (r.kind == FK_BAD_WAVE)
			hdr_wave ^= 32'd1 << $urandom_range(31);
		if (r.kind == FK_NOISE) begin
			put_noise(r.keep);
		end else begin
			put_word(hdr_riff);
			put_word($urandom);
			put_word(hdr_wave);
			for (int i = 0; i < r.pre; i++) begin
				n = (i == 0 && r.zero_size) ? 0 : $urandom_range(12);
				put_word(other_tag());
				put_word(n);
				put_noise(n);
			end
			if (r.kind == FK_HUGE_CHUNK) begin
				put_word(other_tag());
				put_word('1);
				put_noise($urandom_range(1, 40));
			end else begin
				put_word(TAG_SMPL);
				put_word(r.smpl_size);
				put_noise(OFS_COUNT);
				put_word(r.count);
				put_noise(OFS_START - OFS_COUNT - 4);
				put_word(r.first_smp);
				put_word(r.last_smp);
				put_noise($urandom_range(3));
			end
			while (r.keep != 0 && file_q.size() > r.keep)
				void'(file_q.pop_back());
		end
	endfunction

	// entered and left just after a falling edge
	task automatic send_beat(in_beat_t b);
		while (!no_idle && $urandom_range(99) < 37) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= b;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file(file_row_t r);
		build_file(r);
		pin_q.push_back(r);
		foreach (file_q[i])
			send_beat('{data_byte: file_q[i], final_byte: (i == file_q.size() - 1)});
	endtask

	function automatic file_row_t random_row();
		file_row_t r;
		int        k;
		r = '0;
		k = $urandom_range(99);
		r.kind = (k < 62) ? FK_WAV : (k < 70) ? FK_BAD_RIFF : (k < 77) ? FK_BAD_WAVE :
			(k < 90) ? FK_NOISE : FK_HUGE_CHUNK;
		r.pre = 8'($urandom_range(3));
		r.zero_size = ($urandom_range(3) == 0);
		case ($urandom_range(7))
			0: r.count = '0;
			1: r.count = 32'd1 << $urandom_range(31);
			default: r.count = $urandom;
		endcase
		r.first_smp = $urandom;
		r.last_smp = $urandom;
		r.smpl_size = ($urandom_range(3) == 0) ? $urandom : $urandom_range(80);
		if (r.kind == FK_NOISE)
			r.keep = 16'($urandom_range(1, 24));
		else if ($urandom_range(4) == 0)
			r.keep = 16'($urandom_range(1, 90));
		return r;
	endfunction

	always @(negedge clk)
		loop_ready <= no_idle || ($urandom_range(99) >= 37);

	// predictor, result check and watchdog, all on the rising edge
	always @(posedge clk) begin
		out_beat_t want;
		file_row_t pin;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				parse_wav_byte(byte_data.data_byte);
				if (byte_data.final_byte) begin
					want = hit ? out_beat_t'{1'b1, start_v, end_v} : NO_LOOP;
					pin = pin_q.pop_front();
					if (pin.pinned)
						want = pin.want;
					loop_q.push_back(want);
					clear_parser();
				end
			end
			if (loop_valid && loop_ready) begin
				if (loop_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected loop beat: found %0b start %h end %h",
							loop_data.found, loop_data.lp_start, loop_data.lp_end);
				end else begin
					want = loop_q.pop_front();
					if (loop_data.found !== want.found ||
							loop_data.lp_start !== want.lp_start ||
							loop_data.lp_end !== want.lp_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("loop beat mismatch: exp %0b %h %h, got %0b %h %h",
								want.found, want.lp_start, want.lp_end,
								loop_data.found, loop_data.lp_start, loop_data.lp_end);
					end
				end
			end
			if ((byte_valid && byte_ready) || (loop_valid && loop_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		file_row_t r;
		int        files;
		int        sent_bytes;
		clear_parser();
		files = 0;
		sent_bytes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i]) begin
			send_file(dir_rows[i]);
			sent_bytes += file_q.size();
		end
		while (sent_bytes < TOTAL_BYTES) begin
			// a run of files with no idle byte beats and loop_ready held high
			no_idle = (files >= 2 && files < 6);
			r = random_row();
			send_file(r);
			sent_bytes += file_q.size();
			files++;
		end
		no_idle = 1'b0;
		byte_valid <= 1'b0;
		while (loop_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
